### rtl/dtsu_pkg.sv
// Package with the shared constants, types and state encoding of the sync detector and unpacker.
package dtsu_pkg;

   localparam logic [15:0] SYNC14_A = 16'h1FFF;
   localparam logic [15:0] SYNC14_B = 16'hE800;
   localparam logic [15:0] SYNC16_A = 16'h7FFE;
   localparam logic [15:0] SYNC16_B = 16'h8001;
   localparam logic [15:0] MASK14   = 16'h3FFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] word;
      logic        last;
      logic        mode14;
   } word_job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAW14,
      ST_SAW16,
      ST_REPLAY,
      ST_LOCKED
   } front_state_type;

endpackage

### rtl/dtsu_front.sv
// Front end: accepts words, searches for the sync pair and queues words to be unpacked.
module dtsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,
   output logic                  push,
   output dtsu_pkg::word_job_type push_job,
   input  logic                  queue_full
);
   import dtsu_pkg::*;

   front_state_type state_ff;
   front_state_type state_in;
   logic            mode_ff;
   logic            mode_in;
   logic            accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tdata == SYNC14_A) begin
                  state_in = ST_SAW14;
               end else if (req_tdata == SYNC16_A) begin
                  state_in = ST_SAW16;
               end
            end
         end
         ST_SAW14: begin
            if (accept) begin
               if (req_tdata == SYNC14_B) begin
                  state_in = ST_REPLAY;
                  mode_in  = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SAW16: begin
            if (accept) begin
               if (req_tdata == SYNC16_B) begin
                  state_in = ST_REPLAY;
                  mode_in  = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPLAY: begin
            if (!queue_full) begin
               state_in = ST_LOCKED;
            end
         end
         ST_LOCKED: begin
            state_in = ST_LOCKED;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      push            = 1'b0;
      push_job.word   = req_tdata;
      push_job.last   = 1'b1;
      push_job.mode14 = mode_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SAW14: begin
            req_tready      = !queue_full;
            push            = accept && (req_tdata == SYNC14_B);
            push_job.word   = SYNC14_A;
            push_job.last   = 1'b0;
            push_job.mode14 = 1'b1;
         end
         ST_SAW16: begin
            req_tready      = !queue_full;
            push            = accept && (req_tdata == SYNC16_B);
            push_job.word   = SYNC16_A;
            push_job.last   = 1'b0;
            push_job.mode14 = 1'b0;
         end
         ST_REPLAY: begin
            push          = !queue_full;
            push_job.word = mode_ff ? SYNC14_B : SYNC16_B;
         end
         ST_LOCKED: begin
            req_tready = !queue_full;
            push       = accept;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

### rtl/dtsu_queue.sv
// Short queue of unpack jobs between the front end and the unpacker.
module dtsu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dtsu_pkg::word_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output dtsu_pkg::word_job_type head_job
);
   import dtsu_pkg::*;

   word_job_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]         wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]         wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]         rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]         rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]         count_ff;
   logic [QUEUE_CNT_W-1:0]         count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/dtsu_back.sv
// Unpacker: queued words to bytes in the output register, one per cycle unless stalled.
module dtsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  dtsu_pkg::word_job_type head_job,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);
   import dtsu_pkg::*;

   logic        busy_ff;
   logic        busy_in;
   logic [20:0] acc_ff;
   logic [20:0] acc_in;
   logic [4:0]  cnt_ff;
   logic [4:0]  cnt_in;
   logic        last_ff;
   logic        last_in;
   logic        mode_ff;
   logic        mode_in;
   logic [6:0]  pend_bits_ff;
   logic [6:0]  pend_bits_in;
   logic [2:0]  pend_cnt_ff;
   logic [2:0]  pend_cnt_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;
   logic        out_mode_ff;
   logic        fire;
   logic        done;
   logic [4:0]  cnt_rem;
   logic [20:0] shifted;
   logic [7:0]  keep_mask;
   logic [15:0] low14;

   assign fire    = busy_ff && (!out_valid_ff || rsp_tready);
   assign cnt_rem = cnt_ff - 5'd8;
   assign done    = (cnt_rem < 5'd8);
   assign shifted = acc_ff >> cnt_rem;
   assign pop     = head_valid && (!busy_ff || (fire && done));
   assign low14   = head_job.word & MASK14;

   always_comb begin
      keep_mask    = (8'd1 << cnt_rem[2:0]) - 8'd1;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (fire && done && mode_ff) begin
         pend_bits_in = acc_ff[6:0] & keep_mask[6:0];
         pend_cnt_in  = cnt_rem[2:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      mode_in = mode_ff;
      if (fire) begin
         cnt_in = cnt_rem;
         if (done) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         last_in = head_job.last;
         mode_in = head_job.mode14;
         if (head_job.mode14) begin
            acc_in = {pend_bits_in, low14[13:0]};
            cnt_in = {2'b00, pend_cnt_in} + 5'd14;
         end else begin
            acc_in = {5'b00000, head_job.word[7:0], head_job.word[15:8]};
            cnt_in = 5'd16;
         end
      end
   end

   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      mode_ff <= mode_in;
      if (fire) begin
         out_byte_ff <= shifted[7:0];
         out_last_ff <= done && last_ff;
         out_mode_ff <= mode_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_mode_ff;

endmodule

### rtl/dts_sync_detect_and_unpack.sv
// Top level of the sync detector and 14-bit/16-bit word unpacker.
//
// Words arrive on the req_ stream and are searched for a sync pair (0x1FFF then 0xE800
// locks 14-bit packed mode, 0x7FFE then 0x8001 locks 16-bit mode); nothing comes out while
// searching. On lock both sync words are replayed, and every later word is unpacked into
// bytes on the rsp_ stream, with tlast on the final byte of each word but the first sync
// word, and tuser giving the locked mode. The word that completes the sync pair holds off
// further input while the front end queues the second replayed word. The unpacker
// produces one byte per cycle while the output is not stalled; once locked a word gives
// two bytes in 16-bit mode and one or two bytes (1.75 on average) in 14-bit mode. A
// two-entry job queue and the output register let input and output stall independently.
module dts_sync_detect_and_unpack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser   // [0] packed_mode
);
   import dtsu_pkg::*;

   logic         push;
   word_job_type push_job;
   logic         queue_full;
   logic         pop;
   logic         head_valid;
   word_job_type head_job;

   dtsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   dtsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   dtsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
